>>> hw/rtl/msrr_pkg.sv
// Shared types and constants for the two-level process scheduler.
`default_nettype none

package msrr_pkg;

    localparam int NUM_PROCS_DEF = 16;

    localparam int ID_W      = 4;
    localparam int BURST_W   = 16;
    localparam int ENTRY_W   = ID_W + BURST_W;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        RES_ACCEPT = 3'd0,
        RES_REJECT = 3'd1,
        RES_IDLE   = 3'd2,
        RES_RAN    = 3'd3,
        RES_DONE   = 3'd4
    } res_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FREE_SCAN,
        ST_SJF_SCAN,
        ST_SJF_DRAIN,
        ST_EXEC,
        ST_RR_READ,
        ST_RR_RUN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic clr_scan;
        logic idx_inc;
        logic scan_rd;
        logic sjf_insert;
        logic push_arrival;
        logic push_requeue;
        logic reject;
        logic sjf_run;
        logic rr_run;
        logic idle_tick;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic burst_zero;
        logic qsel;
        logic rr_full;
        logic requeue_valid;
        logic job_active;
        logic free_hit;
        logic idx_last;
        logic run_sjf;
        logic rr_nonempty;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/msrr_ctrl.sv
// Scheduler controller: sequencing state machine and output valid flag.
`default_nettype none

module msrr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire msrr_pkg::dp_sts_t sts,
    output msrr_pkg::dp_cmd_t     cmd
);
    import msrr_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (!sts.is_tick) begin
                    if (sts.burst_zero)  state_next = ST_DONE;
                    else if (sts.qsel)   state_next = ST_FREE_SCAN;
                    else                 state_next = ST_DONE;
                end else if (sts.job_active) begin
                    state_next = ST_EXEC;
                end else begin
                    state_next = ST_SJF_SCAN;
                end
            end
            ST_FREE_SCAN: begin
                if (sts.free_hit || sts.idx_last) state_next = ST_DONE;
            end
            ST_SJF_SCAN: begin
                if (sts.idx_last) state_next = ST_SJF_DRAIN;
            end
            ST_SJF_DRAIN: state_next = ST_EXEC;
            ST_EXEC: begin
                if (sts.run_sjf)          state_next = ST_DONE;
                else if (sts.rr_nonempty) state_next = ST_RR_READ;
                else                      state_next = ST_DONE;
            end
            ST_RR_READ: state_next = ST_RR_RUN;
            ST_RR_RUN:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.latch_in = s_tvalid;
            end
            ST_DECODE: begin
                cmd.clr_scan = 1'b1;
                if (!sts.is_tick) begin
                    if (sts.burst_zero)    cmd.reject = 1'b1;
                    else if (!sts.qsel) begin
                        if (sts.rr_full)   cmd.reject = 1'b1;
                        else               cmd.push_arrival = 1'b1;
                    end
                end else begin
                    cmd.push_requeue = sts.requeue_valid;
                end
            end
            ST_FREE_SCAN: begin
                if (sts.free_hit)      cmd.sjf_insert = 1'b1;
                else if (sts.idx_last) cmd.reject = 1'b1;
                else                   cmd.idx_inc = 1'b1;
            end
            ST_SJF_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_EXEC: begin
                if (sts.run_sjf)           cmd.sjf_run = 1'b1;
                else if (!sts.rr_nonempty) cmd.idle_tick = 1'b1;
            end
            ST_RR_RUN: begin
                cmd.rr_run = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load)  m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else               m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/msrr_dp.sv
// Scheduler datapath: slot memory, round-robin ring, running job and time.
`default_nettype none

module msrr_dp #(
    parameter int NUM_PROCS = msrr_pkg::NUM_PROCS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [msrr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [msrr_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic      [msrr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [msrr_pkg::M_TUSER_W-1:0]    m_tuser,
    input  wire msrr_pkg::dp_cmd_t                 cmd,
    output msrr_pkg::dp_sts_t                      sts
);
    import msrr_pkg::*;

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PROCS - 1);

    // memories
    logic [ENTRY_W-1:0] sjf_mem  [NUM_PROCS];
    logic [ENTRY_W-1:0] ring_mem [NUM_PROCS];
    logic [ENTRY_W-1:0] sjf_rd_reg;
    logic [ENTRY_W-1:0] ring_rd_reg;
    logic               ring_we;
    logic [ENTRY_W-1:0] ring_wdata;

    // latched input item
    logic               in_tick_reg, in_qsel_reg;
    logic [ID_W-1:0]    in_id_reg;
    logic [BURST_W-1:0] in_burst_reg;

    // scheduler state
    logic [NUM_PROCS-1:0] used_reg, used_next;
    logic [IDX_W-1:0]     head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 job_active_reg, job_active_next;
    logic [ID_W-1:0]      job_owner_reg, job_owner_next;
    logic [BURST_W-1:0]   job_left_reg, job_left_next;
    logic                 requeue_valid_reg, requeue_valid_next;
    logic [ENTRY_W-1:0]   requeue_entry_reg, requeue_entry_next;
    logic [BURST_W-1:0]   now_reg, now_next;

    // scan
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 cmp_vld_reg, used_q_reg;
    logic [IDX_W-1:0]     slot_q_reg;
    logic                 found_reg, found_next;
    logic [BURST_W-1:0]   best_burst_reg, best_burst_next;
    logic [ID_W-1:0]      best_owner_reg, best_owner_next;
    logic [IDX_W-1:0]     best_slot_reg, best_slot_next;

    // result
    res_status_t          res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [BURST_W-1:0]   res_time_reg, res_time_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    logic [BURST_W-1:0]   now_inc;
    logic [BURST_W-1:0]   cand_burst, left_src, left_dec, rr_left_dec;
    logic [ID_W-1:0]      cand_owner, owner_src;
    logic                 take_cand;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        ring_next = (p == IDX_LAST) ? '0 : p + 1'b1;
    endfunction

    assign now_inc    = now_reg + 1'b1;
    assign cand_burst = sjf_rd_reg[BURST_W-1:0];
    assign cand_owner = sjf_rd_reg[ENTRY_W-1:BURST_W];
    assign take_cand  = cmp_vld_reg && used_q_reg &&
                        (!found_reg || (cand_burst < best_burst_reg) ||
                         ((cand_burst == best_burst_reg) && (cand_owner < best_owner_reg)));
    assign left_src    = job_active_reg ? job_left_reg : best_burst_reg;
    assign owner_src   = job_active_reg ? job_owner_reg : best_owner_reg;
    assign left_dec    = left_src - 1'b1;
    assign rr_left_dec = ring_rd_reg[BURST_W-1:0] - 1'b1;

    assign ring_we    = cmd.push_arrival || cmd.push_requeue;
    assign ring_wdata = cmd.push_requeue ? requeue_entry_reg : {in_id_reg, in_burst_reg};

    always_comb begin
        sts               = '0;
        sts.is_tick       = in_tick_reg;
        sts.burst_zero    = (in_burst_reg == '0);
        sts.qsel          = in_qsel_reg;
        sts.rr_full       = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(requeue_valid_reg))
                            >= (CNT_W+1)'(NUM_PROCS);
        sts.requeue_valid = requeue_valid_reg;
        sts.job_active    = job_active_reg;
        sts.free_hit      = !used_reg[scan_idx_reg];
        sts.idx_last      = (scan_idx_reg == IDX_LAST);
        sts.run_sjf       = job_active_reg || found_reg;
        sts.rr_nonempty   = (count_reg != '0);
    end

    always_comb begin
        used_next          = used_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        job_active_next    = job_active_reg;
        job_owner_next     = job_owner_reg;
        job_left_next      = job_left_reg;
        requeue_valid_next = requeue_valid_reg;
        requeue_entry_next = requeue_entry_reg;
        now_next           = now_reg;
        scan_idx_next      = scan_idx_reg;
        found_next         = found_reg;
        best_burst_next    = best_burst_reg;
        best_owner_next    = best_owner_reg;
        best_slot_next     = best_slot_reg;
        res_status_next    = res_status_reg;
        res_id_next        = res_id_reg;
        res_time_next      = res_time_reg;

        if (take_cand) begin
            found_next      = 1'b1;
            best_burst_next = cand_burst;
            best_owner_next = cand_owner;
            best_slot_next  = slot_q_reg;
        end
        if (cmd.clr_scan) begin
            scan_idx_next = '0;
            found_next    = 1'b0;
        end
        if (cmd.idx_inc || cmd.scan_rd) begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cmd.reject) begin
            res_status_next = RES_REJECT;
            res_id_next     = '0;
            res_time_next   = now_reg;
        end
        if (cmd.sjf_insert) begin
            used_next[scan_idx_reg] = 1'b1;
            res_status_next = RES_ACCEPT;
            res_id_next     = '0;
            res_time_next   = now_reg;
        end
        if (ring_we) begin
            tail_next  = ring_next(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.push_arrival) begin
            res_status_next = RES_ACCEPT;
            res_id_next     = '0;
            res_time_next   = now_reg;
        end
        if (cmd.push_requeue) begin
            requeue_valid_next = 1'b0;
            requeue_entry_next = '0;
        end
        if (cmd.sjf_run) begin
            if (!job_active_reg) used_next[best_slot_reg] = 1'b0;
            now_next        = now_inc;
            job_owner_next  = owner_src;
            job_left_next   = left_dec;
            job_active_next = (left_dec != '0);
            res_status_next = (left_dec == '0) ? RES_DONE : RES_RAN;
            res_id_next     = owner_src;
            res_time_next   = now_inc;
        end
        if (cmd.rr_run) begin
            head_next     = ring_next(head_reg);
            count_next    = count_reg - 1'b1;
            now_next      = now_inc;
            res_id_next   = ring_rd_reg[ENTRY_W-1:BURST_W];
            res_time_next = now_inc;
            if (rr_left_dec == '0) begin
                res_status_next = RES_DONE;
            end else begin
                res_status_next    = RES_RAN;
                requeue_valid_next = 1'b1;
                requeue_entry_next = {ring_rd_reg[ENTRY_W-1:BURST_W], rr_left_dec};
            end
        end
        if (cmd.idle_tick) begin
            now_next        = now_inc;
            res_status_next = RES_IDLE;
            res_id_next     = '0;
            res_time_next   = now_inc;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.sjf_insert) begin
            sjf_mem[scan_idx_reg] <= {in_id_reg, in_burst_reg};
        end
        sjf_rd_reg <= sjf_mem[scan_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[tail_reg] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[head_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_tick_reg  <= s_tuser[0];
            in_qsel_reg  <= s_tuser[1];
            in_id_reg    <= s_tdata[ID_W-1:0];
            in_burst_reg <= s_tdata[ID_W+BURST_W-1:ID_W];
        end
        used_q_reg     <= used_reg[scan_idx_reg];
        slot_q_reg     <= scan_idx_reg;
        best_burst_reg <= best_burst_next;
        best_owner_reg <= best_owner_next;
        best_slot_reg  <= best_slot_next;
        res_id_reg     <= res_id_next;
        res_time_reg   <= res_time_next;
        res_status_reg <= res_status_next;
        if (cmd.out_load) begin
            out_data_reg <= {{(M_TDATA_W-ID_W-BURST_W){1'b0}}, res_time_reg, res_id_reg};
            out_user_reg <= res_status_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg          <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            job_active_reg    <= 1'b0;
            job_owner_reg     <= '0;
            job_left_reg      <= '0;
            requeue_valid_reg <= 1'b0;
            requeue_entry_reg <= '0;
            now_reg           <= '0;
            scan_idx_reg      <= '0;
            cmp_vld_reg       <= 1'b0;
            found_reg         <= 1'b0;
        end else begin
            used_reg          <= used_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            count_reg         <= count_next;
            job_active_reg    <= job_active_next;
            job_owner_reg     <= job_owner_next;
            job_left_reg      <= job_left_next;
            requeue_valid_reg <= requeue_valid_next;
            requeue_entry_reg <= requeue_entry_next;
            now_reg           <= now_next;
            scan_idx_reg      <= scan_idx_next;
            cmp_vld_reg       <= cmd.scan_rd;
            found_reg         <= found_next;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/multilevel_sjf_rr_scheduler.sv
// Top level of the two-level (shortest-job / round-robin) process scheduler.
// Usage:
//   Input channel s_*: one transfer is either a process arrival (s_tuser[0] = 0)
//   or a one-unit time tick (s_tuser[0] = 1). Arrivals carry id and burst in
//   s_tdata and pick the queue with s_tuser[1] (1 = shortest job, 0 = round robin).
//   Result channel m_*: exactly one result transfer per input transfer, in order;
//   m_tuser holds the status code, m_tdata the process that ran and the end time.
// Steps, input transfer to m_tvalid high (one item at a time):
//   round-robin arrival or zero-burst reject: decode, then result load.
//   shortest-job arrival: decode, free-slot scan (one slot per cycle), result load.
//   tick while a shortest job runs: decode, execute, result load; tick with no job
//   running: decode, a one-slot-per-cycle minimum search over the slot memory
//   (single read port), drain, execute (job starts, or idle), and a ring memory
//   read and run when the ring serves, then result load.
// Handshake: s_tready returns in the cycle after the result loads, so a new
//   input is taken only once the block is through with the last one.
// Reset (aresetn low, synchronous): queues empty, no job running, time zero,
//   m_tvalid low. No clearing pass is needed.
// Stall: the result sits in an output register; the next input transfer is taken
//   while it waits, and that item's result holds in the block until m_tready.
`default_nettype none

module multilevel_sjf_rr_scheduler #(
    parameter int NUM_PROCS = msrr_pkg::NUM_PROCS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [3:0] proc_id, [19:4] burst, [23:20] zero
    input  wire logic [msrr_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action, [1] queue_sel
    input  wire logic [msrr_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [3:0] ran_id, [19:4] slot_end, [23:20] zero
    output logic      [msrr_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic      [msrr_pkg::M_TUSER_W-1:0] m_tuser
);
    import msrr_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencing: accept, decode, scans, execute, output load
    msrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queues, running job, time and result registers
    msrr_dp #(
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire

>>> sim/multilevel_sjf_rr_scheduler_tb.sv
// Self-checking testbench for the shortest-job / round-robin process scheduler.
`timescale 1ns / 1ps

module multilevel_sjf_rr_scheduler_tb;
    import msrr_pkg::*;

    localparam int NPROC       = NUM_PROCS_DEF;
    localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES = 40;     // settle time after the last result
    localparam int RANDOM_REQS = 1600;
    localparam int END_TICKS   = 20;     // ticks after the longest shortest job arrives

    // one scheduler request as it travels on s_*
    typedef struct {
        bit               is_tick;
        bit [ID_W-1:0]    proc_id;
        bit [BURST_W-1:0] burst;
        bit               to_sjf;
    } sched_req_t;

    // one scheduler report as it travels on m_*
    typedef struct {
        res_status_t      status;
        bit [ID_W-1:0]    ran_id;
        bit [BURST_W-1:0] slot_end;
    } sched_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [3:0] proc_id, [19:4] burst, [23:20] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] action, [1] queue_sel
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [3:0] ran_id, [19:4] slot_end, [23:20] zero
    logic [M_TDATA_W-1:0] m_tdata;
    // [2:0] status
    logic [M_TUSER_W-1:0] m_tuser;

    multilevel_sjf_rr_scheduler uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sched_req_t sched_requests[$];   // not yet offered on s_*
    sched_res_t due_results[$];      // predicted reports, oldest first
    int         total_requests = 0;
    int         requests_taken = 0;
    int         quiet_cycles   = 0;
    int         mismatches     = 0;
    bit         timed_out      = 1'b0;

    // ---------------------------------------------------------------
    // Scheduler model state
    // ---------------------------------------------------------------
    // shortest-job slots
    bit [BURST_W-1:0] sjf_len  [NPROC];
    bit [ID_W-1:0]    sjf_pid  [NPROC];
    bit               sjf_busy [NPROC];
    // round-robin ring
    bit [ID_W-1:0]    ring_pid [NPROC];
    bit [BURST_W-1:0] ring_left[NPROC];
    int               ring_rd   = 0;
    int               ring_wr   = 0;
    int               ring_fill = 0;
    // running shortest job
    bit               job_on;
    bit [ID_W-1:0]    job_pid;
    bit [BURST_W-1:0] job_remaining;
    // round-robin entry preempted last tick, waits to go back on the ring
    bit               held_valid;
    bit [ID_W-1:0]    held_pid;
    bit [BURST_W-1:0] held_left;
    bit [BURST_W-1:0] now_units;

    initial begin : model_clear
        int i;
        for (i = 0; i < NPROC; i++) sjf_busy[i] = 1'b0;
        job_on        = 1'b0;
        job_pid       = '0;
        job_remaining = '0;
        held_valid    = 1'b0;
        held_pid      = '0;
        held_left     = '0;
        now_units     = '0;
    end

    function automatic void ring_push(bit [ID_W-1:0] pid, bit [BURST_W-1:0] left);
        if (ring_fill >= NPROC) return;
        ring_pid[ring_wr]  = pid;
        ring_left[ring_wr] = left;
        ring_wr            = (ring_wr + 1) % NPROC;
        ring_fill++;
    endfunction

    // Applies one request to the model and returns the report it produces.
    function automatic sched_res_t schedule_step(sched_req_t rq);
        sched_res_t       r;
        int               i;
        int               pick;
        bit [ID_W-1:0]    pid;
        bit [BURST_W-1:0] left;

        r.status   = RES_ACCEPT;
        r.ran_id   = '0;
        r.slot_end = now_units;

        if (!rq.is_tick) begin
            // arrival: zero burst or a full queue bounces it
            if (rq.burst == 0) begin
                r.status = RES_REJECT;
            end else if (rq.to_sjf) begin
                pick = -1;
                for (i = 0; i < NPROC; i++)
                    if (!sjf_busy[i] && pick < 0) pick = i;
                if (pick < 0) begin
                    r.status = RES_REJECT;
                end else begin
                    sjf_busy[pick] = 1'b1;
                    sjf_len[pick]  = rq.burst;
                    sjf_pid[pick]  = rq.proc_id;
                end
            end else if (ring_fill + (held_valid ? 1 : 0) >= NPROC) begin
                // room is kept for the pending requeue
                r.status = RES_REJECT;
            end else begin
                ring_push(rq.proc_id, rq.burst);
            end
            return r;
        end

        // tick: the preempted entry goes back behind this unit's arrivals
        if (held_valid) begin
            ring_push(held_pid, held_left);
            held_valid = 1'b0;
        end

        // decision point: least burst, then lower id, then lower slot
        if (!job_on) begin
            pick = -1;
            for (i = 0; i < NPROC; i++)
                if (sjf_busy[i] && (pick < 0 || sjf_len[i] < sjf_len[pick] ||
                    (sjf_len[i] == sjf_len[pick] && sjf_pid[i] < sjf_pid[pick])))
                    pick = i;
            if (pick >= 0) begin
                job_on         = 1'b1;
                job_pid        = sjf_pid[pick];
                job_remaining  = sjf_len[pick];
                sjf_busy[pick] = 1'b0;
            end
        end

        now_units  = now_units + 1'b1;
        r.slot_end = now_units;

        if (job_on) begin
            // shortest job runs to completion, no preemption
            job_remaining = job_remaining - 1'b1;
            r.ran_id      = job_pid;
            if (job_remaining == 0) begin
                job_on   = 1'b0;
                r.status = RES_DONE;
            end else begin
                r.status = RES_RAN;
            end
        end else if (ring_fill > 0) begin
            // quantum of one unit
            pid       = ring_pid[ring_rd];
            left      = ring_left[ring_rd] - 1'b1;
            ring_rd   = (ring_rd + 1) % NPROC;
            ring_fill--;
            r.ran_id  = pid;
            if (left == 0) begin
                r.status = RES_DONE;
            end else begin
                r.status   = RES_RAN;
                held_valid = 1'b1;
                held_pid   = pid;
                held_left  = left;
            end
        end else begin
            r.status = RES_IDLE;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_arrival(bit [ID_W-1:0] pid, bit [BURST_W-1:0] burst, bit to_sjf);
        sched_req_t rq;
        rq.is_tick = 1'b0;
        rq.proc_id = pid;
        rq.burst   = burst;
        rq.to_sjf  = to_sjf;
        sched_requests.insert(sched_requests.size(), rq);
    endtask

    // ticks carry junk in the unused fields; the block must ignore it
    task automatic add_ticks(int n);
        sched_req_t rq;
        repeat (n) begin
            rq.is_tick = 1'b1;
            rq.proc_id = ID_W'($urandom_range(0, 15));
            rq.burst   = BURST_W'($urandom_range(0, 65535));
            rq.to_sjf  = 1'($urandom_range(0, 1));
            sched_requests.insert(sched_requests.size(), rq);
        end
    endtask

    // idle share in percent, by phase of the run
    function automatic int idle_pct(bit sender_side);
        if (requests_taken < 550)  return sender_side ? 30 : 72;
        if (requests_taken < 1100) return sender_side ? 72 : 30;
        return 0;
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued requests on s_*, with random gaps
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : driver
        sched_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (sched_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                rq       = sched_requests[0];
                sched_requests.delete(0);
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, rq.burst, rq.proc_id};
                s_tuser  <= {rq.to_sjf, rq.is_tick};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each result
    // transfer, drives m_tready and runs the watchdog
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        sched_req_t got;
        sched_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));

            // predict first so a same-edge result never sees a stale queue
            if (s_tvalid && s_tready) begin
                got.is_tick = s_tuser[0];
                got.to_sjf  = s_tuser[1];
                got.proc_id = s_tdata[3:0];
                got.burst   = s_tdata[19:4];
                due_results.insert(due_results.size(), schedule_step(got));
                requests_taken <= requests_taken + 1;
            end

            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $error("unexpected result: status %0d ran_id %0d slot_end %0d",
                           m_tuser, m_tdata[3:0], m_tdata[19:4]);
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (m_tuser !== want.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                    end
                    if (m_tdata[3:0] !== want.ran_id) begin
                        mismatches++;
                        $error("ran_id: expected %0d, got %0d", want.ran_id, m_tdata[3:0]);
                    end
                    if (m_tdata[19:4] !== want.slot_end) begin
                        mismatches++;
                        $error("slot_end: expected %0d, got %0d",
                               want.slot_end, m_tdata[19:4]);
                    end
                end
            end

            // watchdog: any transfer on either side restarts the count
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
                timed_out <= 1'b1;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial begin : stimulus
        int               added;
        int               seg_len;
        int               tick_pct;
        int               k;
        int               sel;
        bit               to_sjf;
        bit [BURST_W-1:0] burst;

        // -- directed part --
        add_ticks(1);                        // empty scheduler: idle tick
        add_arrival(4'd15, 16'd0, 1'b0);     // zero burst, round robin: reject
        add_arrival(4'd0,  16'd0, 1'b1);     // zero burst, shortest job: reject
        add_arrival(4'd3,  16'd2, 1'b0);
        add_ticks(1);                        // 3 runs one unit, preempted
        add_arrival(4'd10, 16'd1, 1'b0);     // lands ahead of the requeued 3
        add_ticks(1);                        // 10 runs and finishes
        add_arrival(4'd6,  16'd2, 1'b1);
        add_arrival(4'd4,  16'd2, 1'b1);     // equal burst, lower id wins over 6
        add_arrival(4'd4,  16'd2, 1'b1);     // same burst and id: lower slot first
        add_arrival(4'd9,  16'd1, 1'b1);     // least burst
        add_arrival(4'd12, 16'hFFFF, 1'b0);  // huge round-robin burst
        add_ticks(2);                        // 9 finishes, 4 starts
        add_arrival(4'd1,  16'd1, 1'b1);     // shorter, but 4 is not preempted
        add_ticks(8);                        // drain into round robin

        // -- random part: segments leaning to arrivals or to ticks --
        added = 0;
        while (added < RANDOM_REQS) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       tick_pct = 15;  // queues fill up, rejects show
                1:       tick_pct = 50;
                default: tick_pct = 85;  // drain, idle ticks show
            endcase
            for (k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 99) < tick_pct) begin
                    add_ticks(1);
                end else begin
                    to_sjf = 1'($urandom_range(0, 1));
                    sel    = $urandom_range(0, 199);
                    if (sel < 6) begin
                        burst = '0;
                    end else if (sel < 7) begin
                        // wide bursts only on the ring; a long shortest job
                        // would hog every later tick
                        burst  = BURST_W'($urandom_range(1, 65535));
                        to_sjf = 1'b0;
                    end else if (sel < 40) begin
                        burst = BURST_W'($urandom_range(1, 12));
                    end else begin
                        burst = BURST_W'($urandom_range(1, 4));
                    end
                    add_arrival(ID_W'($urandom_range(0, 15)), burst, to_sjf);
                end
            end
            added += seg_len;
        end

        // -- longest shortest job, started but not finished --
        add_arrival(4'd11, 16'hFFFF, 1'b1);
        add_ticks(END_TICKS);

        total_requests = sched_requests.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (!timed_out &&
               !(requests_taken == total_requests && due_results.size() == 0))
            @(posedge aclk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge aclk);

        if (!timed_out && mismatches == 0 && due_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/msrr_pkg.sv
hw/rtl/msrr_ctrl.sv
hw/rtl/msrr_dp.sv
hw/rtl/multilevel_sjf_rr_scheduler.sv
sim/multilevel_sjf_rr_scheduler_tb.sv
